/* rtl/core/rle_pkg.sv */
// types and constants of the recency list with eviction
// no dependencies
package rle_pkg;

  localparam int unsigned KEY_W  = 32;
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned CAP_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_LIST   = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
  } in_word_t;

  typedef struct packed {
    logic [KEY_W-1:0] entry_key;
    logic             is_empty;
    logic             last;
  } out_word_t;

  // broadcast command to every cell of the chain
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic             rot;
    logic [KEY_W-1:0] key;
  } cell_cmd_t;

endpackage

/* rtl/core/rle_cell.sv */
// one position of the recency chain: holds a key, compares, shifts
// depends on rle_pkg
module rle_cell #(
  parameter int unsigned CNT_W = 5,
  parameter int unsigned IDX   = 0
) (
  input  logic                       clk_i,
  input  rle_pkg::cell_cmd_t         cmd_i,
  input  logic [CNT_W-1:0]           count_i,
  input  logic                       hit_left_i,
  input  logic [rle_pkg::KEY_W-1:0]  left_key_i,
  input  logic [rle_pkg::KEY_W-1:0]  right_key_i,
  input  logic [rle_pkg::KEY_W-1:0]  head_key_i,
  output logic [rle_pkg::KEY_W-1:0]  key_o,
  output logic                       hit_o
);
  import rle_pkg::*;

  logic [KEY_W-1:0] key_q, key_d;
  logic             valid, tail, match;

  assign valid = CNT_W'(IDX) < count_i;
  assign tail  = count_i == CNT_W'(IDX + 1);
  assign match = valid && (key_q == cmd_i.key);
  assign hit_o = hit_left_i | match;
  assign key_o = key_q;

  always_comb begin
    key_d = key_q;
    if (cmd_i.ins) begin
      // everything up to the old copy of the key moves one place back
      if (!hit_left_i) begin
        key_d = left_key_i;
      end
    end else if (cmd_i.rem) begin
      // close the gap behind the removed key
      if (hit_o) begin
        key_d = right_key_i;
      end
    end else if (cmd_i.rot) begin
      key_d = tail ? head_key_i : right_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

/* rtl/core/recency_list_with_eviction_unit.sv */
// recency list: insert, remove or clear are taken back to back
// listing n entries streams max(n,1) words through the output register, one
// per cycle while the output is not stalled; the next item is taken once the
// last word is loaded; pace of a listing is set by the chain rotating
// one place per word; reset: list empty, capacity 16, stored keys undefined
module recency_list_with_eviction_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rle_pkg::in_word_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rle_pkg::out_word_t  out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [rle_pkg::CAP_W-1:0] cfg_data_i
);
  import rle_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LIST = 2'b10
  } state_e;

  state_e              state_q, state_d;
  logic [CAP_W-1:0]    cap_q;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    idx_q, idx_d;
  logic                out_valid_q, out_valid_d;
  out_word_t           out_q, out_d;

  logic [CNT_W-1:0]    eff_cap;
  logic [CNT_W-1:0]    cnt_after_drop;
  logic                in_acc, out_free, emit, found;
  cell_cmd_t           cmd;

  // chain wiring: keys of each cell and the running match prefix
  logic [KEY_W-1:0]    cell_key [DEPTH];
  logic [DEPTH:0]      hit_chain;

  // config port: always writable, only used while idle
  assign cfg_ready_o = 1'b1;

  // capacity zero acts as one, above the chain length acts as the chain length
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CNT_W'(1);
    end else if (int'(cap_q) > DEPTH) begin
      eff_cap = CNT_W'(DEPTH);
    end else begin
      eff_cap = CNT_W'(cap_q);
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign emit       = (state_q == ST_LIST) && out_free;

  // command broadcast to all cells
  assign cmd.ins = in_acc && (in_data_i.func == FUNC_INSERT);
  assign cmd.rem = in_acc && (in_data_i.func == FUNC_REMOVE);
  assign cmd.rot = emit && (count_q != '0);
  assign cmd.key = in_data_i.key;

  assign hit_chain[0] = 1'b0;
  assign found        = hit_chain[DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_W-1:0] left_key, right_key;
    // head cell takes the incoming key, the tail cell has no right neighbor
    if (i == 0) begin : g_head
      assign left_key = in_data_i.key;
    end else begin : g_mid
      assign left_key = cell_key[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_key = cell_key[i];
    end else begin : g_body
      assign right_key = cell_key[i+1];
    end

    rle_cell #(
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .count_i     (count_q),
      .hit_left_i  (hit_chain[i]),
      .left_key_i  (left_key),
      .right_key_i (right_key),
      .head_key_i  (cell_key[0]),
      .key_o       (cell_key[i]),
      .hit_o       (hit_chain[i+1])
    );
  end

  // count after dropping an equal key, used by insert and remove
  assign cnt_after_drop = count_q - CNT_W'(found);

  always_comb begin
    count_d = count_q;
    if (cmd.ins) begin
      // evict the oldest entries so the new key fits within capacity
      if (cnt_after_drop >= eff_cap) begin
        count_d = eff_cap;
      end else begin
        count_d = cnt_after_drop + CNT_W'(1);
      end
    end else if (cmd.rem) begin
      count_d = cnt_after_drop;
    end else if (in_acc && (in_data_i.func == FUNC_CLEAR)) begin
      count_d = '0;
    end
  end

  // listing sequencer: rotate the chain once per word, head goes out
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_data_i.func == FUNC_LIST)) begin
          state_d = ST_LIST;
          idx_d   = '0;
        end
      end
      ST_LIST: begin
        if (emit) begin
          out_valid_d = 1'b1;
          if (count_q == '0) begin
            // empty list gives a single flagged word
            out_d.entry_key = '0;
            out_d.is_empty  = 1'b1;
            out_d.last      = 1'b1;
            state_d         = ST_IDLE;
          end else begin
            out_d.entry_key = cell_key[0];
            out_d.is_empty  = 1'b0;
            out_d.last      = (idx_q == count_q - CNT_W'(1));
            idx_d           = idx_q + CNT_W'(1);
            if (idx_q == count_q - CNT_W'(1)) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= CAP_RESET;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  // output word register, payload only
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // the list never holds more entries than there are cells
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_q) <= DEPTH)
    else $error("entry count exceeds chain length");

  // an insert always leaves at least one entry behind
  a_insert_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ins |=> count_q != '0)
    else $error("insert left the list empty");

  // while listing, the word index stays inside the list
  a_list_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LIST) && (count_q != '0) |-> idx_q < count_q)
    else $error("listing index past the end");

  // an empty marker is always the final word of its listing
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_empty |-> out_data_o.last)
    else $error("empty word without last flag");

endmodule

/* test/recency_list_checker.sv */
// tracks the recency list from the accepted words and checks every listing word
// depends on rle_pkg for the word types, the operation codes and the reset capacity
module recency_list_checker #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  rle_pkg::in_word_t         in_data_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  rle_pkg::out_word_t        out_data_i,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [rle_pkg::CAP_W-1:0] cfg_data_i,
  output int                        fail_count_o,
  output int                        pending_o
);
  import rle_pkg::*;

  localparam int REPORT_LIMIT = 100;

  logic [KEY_W-1:0] held_keys [DEPTH];
  int               held_count;
  logic [CAP_W-1:0] capacity_q;
  out_word_t        listing_q [$];
  int               mismatches;
  int               owed;

  assign fail_count_o = mismatches;
  assign pending_o    = owed;

  // zero and oversized settings are clamped
  function automatic int cap_limit();
    int c;
    c = int'(capacity_q);
    if (c == 0) c = 1;
    if (c > int'(DEPTH)) c = int'(DEPTH);
    return c;
  endfunction

  function automatic void drop_key(input logic [KEY_W-1:0] k);
    int hit;
    hit = -1;
    for (int i = 0; i < held_count; i++)
      if (hit < 0 && held_keys[i] === k) hit = i;
    if (hit >= 0) begin
      for (int j = hit; j + 1 < held_count; j++) held_keys[j] = held_keys[j + 1];
      held_count--;
    end
  endfunction

  // trims to capacity-1 older entries, so a lowered capacity bites here
  function automatic void put_front(input logic [KEY_W-1:0] k);
    int lim;
    lim = cap_limit();
    if (held_count >= lim) held_count = lim - 1;
    for (int i = held_count; i > 0; i--) held_keys[i] = held_keys[i - 1];
    held_keys[0] = k;
    held_count++;
  endfunction

  function automatic void queue_listing();
    out_word_t w;
    if (held_count == 0) begin
      w.entry_key = '0;
      w.is_empty  = 1'b1;
      w.last      = 1'b1;
      listing_q.push_back(w);
    end else begin
      for (int i = 0; i < held_count; i++) begin
        w.entry_key = held_keys[i];
        w.is_empty  = 1'b0;
        w.last      = (i == held_count - 1);
        listing_q.push_back(w);
      end
    end
  endfunction

  function automatic void apply_word(input in_word_t w);
    case (w.func)
      FUNC_INSERT: begin
        drop_key(w.key);
        put_front(w.key);
      end
      FUNC_REMOVE: drop_key(w.key);
      FUNC_CLEAR:  held_count = 0;
      default:     queue_listing();
    endcase
  endfunction

  function automatic void note_mismatch(input string field, input logic [KEY_W-1:0] want,
                                        input logic [KEY_W-1:0] got);
    if (mismatches < REPORT_LIMIT)
      $error("%s mismatch: expected %h, actual %h", field, want, got);
    mismatches++;
  endfunction

  function automatic void check_word(input out_word_t got);
    out_word_t want;
    if (listing_q.size() == 0) begin
      if (mismatches < REPORT_LIMIT)
        $error("unexpected word: entry_key %h is_empty %b last %b",
               got.entry_key, got.is_empty, got.last);
      mismatches++;
    end else begin
      want = listing_q.pop_front();
      if (got.entry_key !== want.entry_key)
        note_mismatch("entry_key", want.entry_key, got.entry_key);
      if (got.is_empty !== want.is_empty)
        note_mismatch("is_empty", KEY_W'(want.is_empty), KEY_W'(got.is_empty));
      if (got.last !== want.last)
        note_mismatch("last", KEY_W'(want.last), KEY_W'(got.last));
    end
  endfunction

  initial mismatches = 0;

  // words leaving are checked before a word entering at the same edge is applied
  // a capacity written at the same edge only counts from the next word on
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      listing_q.delete();
      held_count = 0;
      capacity_q = CAP_RESET;
      owed       = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_word(out_data_i);
      if (in_valid_i && in_ready_i) apply_word(in_data_i);
      if (cfg_valid_i && cfg_ready_i) capacity_q = cfg_data_i;
      owed = listing_q.size();
    end
  end

endmodule

/* test/recency_list_with_eviction_unit_tb.sv */
// stimulus and verdict for the recency list with eviction unit
// depends on rle_pkg, the unit itself and recency_list_checker
module recency_list_with_eviction_unit_tb;
  import rle_pkg::*;

  localparam int unsigned LIST_DEPTH = 16;
  // a listing is done once its last word is taken
  localparam int DRAIN_CYCLES = 4;
  localparam int KEY_POOL     = 20;
  localparam int PHASE_ITEMS  = 40;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_word_t         in_data;
  logic             out_valid;
  logic             out_ready;
  out_word_t        out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data;

  int               fail_count;
  int               words_owed;
  // when set, neither side inserts gaps
  bit               steady;
  logic [KEY_W-1:0] key_pool [KEY_POOL];

  always #5 clk = ~clk;

  recency_list_with_eviction_unit #(
    .DEPTH(LIST_DEPTH)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  recency_list_checker #(
    .DEPTH(LIST_DEPTH)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .fail_count_o(fail_count),
    .pending_o   (words_owed)
  );

  // mostly back to back or short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // reuse a small pool so that inserts and removes hit stored keys
  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 80) return key_pool[$urandom_range(0, KEY_POOL - 1)];
    return $urandom;
  endfunction

  function automatic logic [FUNC_W-1:0] pick_func();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return FUNC_INSERT;
    if (r < 70) return FUNC_REMOVE;
    if (r < 92) return FUNC_LIST;
    return FUNC_CLEAR;
  endfunction

  // called at a falling edge, returns at the falling edge after the word is taken
  // with valid still high, so a following word can go out with no gap
  task automatic send_word(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data.func <= f;
    in_data.key  <= k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // input side quiet, every listing word delivered, unit settled
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (words_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // random traffic; at pause_at the sender holds off until the list is drained
  task automatic run_phase(input int n, input int pause_at);
    logic [FUNC_W-1:0] f;
    for (int i = 0; i < n; i++) begin
      if (i == pause_at) wait_drained();
      f = pick_func();
      if (f == FUNC_INSERT || f == FUNC_REMOVE) send_word(f, pick_key());
      else send_word(f, $urandom);
    end
  endtask

  // receiver: ready for a while, then a stall of random length
  initial begin
    int hold;
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      hold  = $urandom_range(1, 12);
      stall = pick_gap();
      out_ready <= 1'b1;
      repeat (hold) @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = CAP_RESET;
    steady    = 1'b0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // basic operations at the reset capacity
    send_word(FUNC_LIST, 32'h0000_0000);     // empty list gives one empty word
    send_word(FUNC_INSERT, 32'h0000_0000);
    send_word(FUNC_INSERT, 32'hFFFF_FFFF);
    send_word(FUNC_INSERT, 32'h1234_5678);
    send_word(FUNC_LIST, 32'hFFFF_FFFF);
    send_word(FUNC_INSERT, 32'h0000_0000);   // already held, moves to the front
    send_word(FUNC_REMOVE, 32'hA5A5_A5A5);   // absent key, no change
    send_word(FUNC_REMOVE, 32'hFFFF_FFFF);   // oldest entry, removed from the tail
    send_word(FUNC_LIST, 32'h5A5A_5A5A);
    send_word(FUNC_CLEAR, 32'hDEAD_BEEF);
    send_word(FUNC_LIST, 32'h0000_0001);
    send_word(FUNC_REMOVE, 32'h0000_0000);   // remove on an empty list

    // eviction of the oldest at a small capacity
    write_capacity(CAP_W'(2));
    send_word(FUNC_INSERT, 32'h0000_0001);
    send_word(FUNC_INSERT, 32'h0000_0002);
    send_word(FUNC_INSERT, 32'h0000_0003);
    send_word(FUNC_INSERT, 32'h0000_0002);   // duplicate while full, nothing evicted
    send_word(FUNC_LIST, 32'h0000_0000);

    // capacity lowered below the count: kept until the next insert trims
    write_capacity(CAP_W'(16));
    for (int i = 0; i < 6; i++) send_word(FUNC_INSERT, 32'h0000_0010 + i);
    write_capacity(CAP_W'(3));
    send_word(FUNC_LIST, 32'h0000_0000);
    send_word(FUNC_INSERT, 32'h0000_0099);
    send_word(FUNC_LIST, 32'h0000_0000);

    // zero capacity behaves as one
    write_capacity(CAP_W'(0));
    send_word(FUNC_INSERT, 32'h0000_0007);
    send_word(FUNC_INSERT, 32'h0000_0008);
    send_word(FUNC_LIST, 32'h0000_0000);

    // largest field value clamps to the depth, so a full list of 16 words
    write_capacity(CAP_W'(31));
    for (int i = 0; i < 18; i++) send_word(FUNC_INSERT, 32'h8000_0000 + i);
    send_word(FUNC_LIST, 32'h0000_0000);

    // random traffic under several capacities
    write_capacity(CAP_W'(16));
    run_phase(PHASE_ITEMS, PHASE_ITEMS / 2);
    write_capacity(CAP_W'(1));
    run_phase(PHASE_ITEMS, -1);
    write_capacity(CAP_W'(31));
    steady = 1'b1;
    run_phase(PHASE_ITEMS, -1);
    steady = 1'b0;
    write_capacity(CAP_W'(0));
    run_phase(PHASE_ITEMS, -1);
    write_capacity(CAP_W'($urandom_range(2, 15)));
    run_phase(PHASE_ITEMS, -1);

    // all words owed have arrived, give stray words a chance to show up
    wait_drained();
    repeat (4 * DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
